### rtl/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

  // parser phase codes
  localparam logic [2:0] PH_PLAIN = 3'd0;
  localparam logic [2:0] PH_ESC   = 3'd1;
  localparam logic [2:0] PH_HEX1  = 3'd2;
  localparam logic [2:0] PH_HEX4  = 3'd5;

  // result kinds
  localparam logic [1:0] K_BYTE  = 2'd0;
  localparam logic [1:0] K_CLOSE = 2'd1;
  localparam logic [1:0] K_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] E_NONE   = 2'd0;
  localparam logic [1:0] E_ESCAPE = 2'd1;
  localparam logic [1:0] E_HEX    = 2'd2;
  localparam logic [1:0] E_UNTERM = 2'd3;

  localparam int MaxBytes = 3;

  // one queued job: up to three result items caused by one input item
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               cnt;
    logic [1:0]               kind;
    logic [1:0]               ecode;
  } jsu_entry_t;

endpackage
`default_nettype wire

### rtl/jsu_front.sv
`default_nettype none
module jsu_front
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_text_end,
  input  wire logic       q_full,
  output logic            q_push,
  output jsu_entry_t      q_data
);

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [2:0]  ph;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [7:0]  esc_byte;
  logic        esc_ok;
  logic [15:0] cp_acc;
  logic        emit;
  logic        restart;
  logic        accept;
  jsu_entry_t  ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    digit    = 4'd0;
    digit_ok = 1'b1;
    case (in_char_in) inside
      [8'h30:8'h39]: digit = 4'(in_char_in - 8'h30);
      [8'h61:8'h66]: digit = 4'(in_char_in - 8'h57);
      [8'h41:8'h46]: digit = 4'(in_char_in - 8'h37);
      default: digit_ok = 1'b0;
    endcase
  end

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_char_in;
    case (in_char_in)
      8'h22, 8'h5c, 8'h2f: esc_byte = in_char_in;
      8'h62: esc_byte = 8'h08;
      8'h66: esc_byte = 8'h0c;
      8'h6e: esc_byte = 8'h0a;
      8'h72: esc_byte = 8'h0d;
      8'h74: esc_byte = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  assign cp_acc = {cp_r[11:0], digit};

  always_comb begin
    ph        = (phase_r > PH_HEX4) ? PH_PLAIN : phase_r;
    phase_nxt = ph;
    cp_nxt    = cp_r;
    emit      = 1'b0;
    restart   = 1'b0;
    ent       = '0;
    ent.cnt   = 2'd1;
    ent.kind  = K_BYTE;
    ent.ecode = E_NONE;
    case (ph)
      PH_PLAIN: begin
        if (in_char_in == 8'h22) begin
          restart  = 1'b1;
          ent.kind = K_CLOSE;
        end else if (in_char_in == 8'h5c) begin
          phase_nxt = PH_ESC;
        end else begin
          emit         = 1'b1;
          ent.bytes[0] = in_char_in;
        end
      end
      PH_ESC: begin
        if (in_char_in == 8'h75) begin
          phase_nxt = PH_HEX1;
          cp_nxt    = '0;
        end else if (esc_ok) begin
          emit         = 1'b1;
          ent.bytes[0] = esc_byte;
          phase_nxt    = PH_PLAIN;
        end else begin
          restart   = 1'b1;
          ent.kind  = K_ERROR;
          ent.ecode = E_ESCAPE;
        end
      end
      default: begin
        if (!digit_ok) begin
          restart   = 1'b1;
          ent.kind  = K_ERROR;
          ent.ecode = E_HEX;
        end else if (ph == PH_HEX4) begin
          phase_nxt = PH_PLAIN;
          cp_nxt    = '0;
          if (cp_acc[15:11] == 5'b11011) begin
            // surrogate range
            restart   = 1'b1;
            ent.kind  = K_ERROR;
            ent.ecode = E_HEX;
          end else if (cp_acc < 16'h0080) begin
            emit         = 1'b1;
            ent.bytes[0] = cp_acc[7:0];
          end else if (cp_acc < 16'h0800) begin
            emit         = 1'b1;
            ent.cnt      = 2'd2;
            ent.bytes[0] = {3'b110, cp_acc[10:6]};
            ent.bytes[1] = {2'b10, cp_acc[5:0]};
          end else begin
            emit         = 1'b1;
            ent.cnt      = 2'd3;
            ent.bytes[0] = {4'b1110, cp_acc[15:12]};
            ent.bytes[1] = {2'b10, cp_acc[11:6]};
            ent.bytes[2] = {2'b10, cp_acc[5:0]};
          end
        end else begin
          phase_nxt = ph + 3'd1;
          cp_nxt    = cp_acc;
        end
      end
    endcase
    // end of text wins over anything but a close or a hard error
    if (in_text_end && !restart) begin
      restart   = 1'b1;
      ent       = '0;
      ent.cnt   = 2'd1;
      ent.kind  = K_ERROR;
      ent.ecode = E_UNTERM;
    end
    if (restart) begin
      phase_nxt = PH_PLAIN;
      cp_nxt    = '0;
    end
  end

  assign q_push = accept && (emit || restart);
  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      cp_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cp_r    <= cp_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/jsu_fifo.sv
`default_nettype none
module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  jsu_entry_t      push_data,
  output logic            full,
  input  wire logic       pop,
  output jsu_entry_t      head,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  jsu_entry_t    store_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == LastIdx) ? '0 : wr_r + AW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == LastIdx) ? '0 : rd_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/jsu_back.sv
`default_nettype none
module jsu_back
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  jsu_entry_t      q_head,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_out_byte,
  output logic [1:0]      out_kind,
  output logic [1:0]      out_error_code,
  output logic            out_last
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic [1:0] kind_r, ecode_r;
  logic       last_r;
  logic [1:0] idx_r;
  logic       load;
  logic       at_last;

  assign load    = !q_empty && (!valid_r || out_ready);
  assign at_last = (idx_r == q_head.cnt - 2'd1);
  assign q_pop   = load && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= q_head.bytes[idx_r];
      kind_r  <= q_head.kind;
      ecode_r <= q_head.ecode;
      last_r  <= at_last;
    end
  end

  assign out_valid      = valid_r;
  assign out_out_byte   = byte_r;
  assign out_kind       = kind_r;
  assign out_error_code = ecode_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire

### rtl/json_string_unescape_unit.sv
// Streaming unescaper for the body of a JSON string, one byte per input item.
// Input channel: in_valid/in_ready carrying in_char_in and in_text_end.
// Result channel: out_valid/out_ready carrying out_out_byte, out_kind,
// out_error_code and out_last; an input item gives zero to three results,
// the final one marked by out_last.
// The front stage decodes one byte per cycle while the queue has room and
// writes any job it yields into a queue of QUEUE_DEPTH entries; the back
// stage sends one result per cycle, while the receiver is ready, from the
// queue head through an output register, so the first result of an input
// item is registered in the queue and then in the output register.
// Throughput: one input item per cycle while results keep pace; a u escape
// that expands to two or three UTF-8 bytes holds the result port for one
// result per byte, and input then stalls only when the queue fills.
// When the receiver stalls, the output register holds its item and the
// queue absorbs further jobs; in_ready drops once the queue is full.
// Reset (synchronous, active low) empties the queue and the output register
// and returns the parser to plain text.
`default_nettype none
module json_string_unescape_unit
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_text_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_out_byte,
  output logic [1:0]      out_kind,
  output logic [1:0]      out_error_code,
  output logic            out_last
);

  jsu_entry_t push_data, head;
  logic       push, full, pop, empty;

  jsu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char_in  (in_char_in),
    .in_text_end (in_text_end),
    .q_full      (full),
    .q_push      (push),
    .q_data      (push_data)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  jsu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (head),
    .q_empty        (empty),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire
